FILE: rtl/spem_pkg.sv
// Shared types and constants for the Sobel/Prewitt edge magnitude block.
`default_nettype none
package spem_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned RowW  = 12;
  localparam int unsigned ColW  = 10;
  localparam int unsigned AbsW  = 10;
  localparam int unsigned CfgW  = 13;
  localparam int unsigned IdxW  = 2;

  localparam logic [IdxW-1:0] RegEdgeMode   = 2'd0;
  localparam logic [IdxW-1:0] RegFrameWidth = 2'd1;
  localparam logic [IdxW-1:0] RegFrameHeight = 2'd2;

  localparam logic ModeSobel   = 1'b0;
  localparam logic ModePrewitt = 1'b1;

  localparam logic [10:0] FrameWidthRst  = 11'd1024;
  localparam logic [12:0] FrameHeightRst = 13'd768;

  typedef struct packed {
    logic [PixW-1:0] pixel_value;
    logic            frame_start;
  } pix_t;

  typedef struct packed {
    logic [RowW-1:0] out_row;
    logic [ColW-1:0] out_col;
    logic [PixW-1:0] edge_value;
    logic            last_of_run;
  } res_t;

  // One classified input: one or two results, the first may need a magnitude.
  typedef struct packed {
    logic            two;
    logic            mag;
    logic            mode;
    logic [RowW-1:0] row0;
    logic [ColW-1:0] col0;
    logic [RowW-1:0] row1;
    logic [ColW-1:0] col1;
    logic [AbsW-1:0] ax;
    logic [AbsW-1:0] ay;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/spem_stream_if.sv
// Valid/ready stream channel carrying one item type.
`default_nettype none
interface spem_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/spem_front.sv
// Front end: configuration, position counters, line store, window and gradients.
`default_nettype none
module spem_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [spem_pkg::IdxW-1:0] cfg_idx_i,
  input  wire logic [spem_pkg::CfgW-1:0] cfg_data_i,
  spem_stream_if.sink                  pix_i,
  output      logic                    push_o,
  output      spem_pkg::job_t          job_o,
  input  wire logic                    full_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);

  typedef enum logic {F_IDLE, F_CALC} fstate_e;

  fstate_e           state_q;
  logic              mode_q;
  logic [10:0]       fw_q;
  logic [12:0]       fh_q;
  logic [CW-1:0]     col_q, c_q;
  logic [RW-1:0]     row_q, r_q;
  logic [7:0]        px_q;
  logic [15:0]       rd_q;
  logic [7:0]        win_q [6];
  logic [15:0]       mem_q [MAX_WIDTH];

  logic [CW-1:0]     w_eff, c0, c1, nc;
  logic [RW-1:0]     h_eff, r0, r1, r2, nr;
  logic              acc, fire;
  logic [7:0]        top, mid;
  logic [11:0]       lx, rx, ty, by;
  logic [11:0]       gx, gy;
  spem_pkg::job_t    job;
  logic              has;

  always_comb begin
    if (fw_q < 11'd3) begin
      w_eff = CW'(3);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(fw_q);
    end
    if (fh_q < 13'd3) begin
      h_eff = RW'(3);
    end else if (32'(fh_q) > 32'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(fh_q);
    end
  end

  // Position of the accepted item, with wrap after size changes.
  always_comb begin
    c0 = pix_i.data.frame_start ? '0 : col_q;
    r0 = pix_i.data.frame_start ? '0 : row_q;
    c1 = c0;
    r1 = r0;
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + RW'(1);
    end
    r2 = (r1 >= h_eff) ? '0 : r1;
    nc = c1 + CW'(1);
    nr = r2 + RW'(1);
  end

  assign pix_i.ready = (state_q == F_IDLE);
  assign acc = pix_i.valid && pix_i.ready;

  assign top = rd_q[7:0];
  assign mid = rd_q[15:8];

  always_comb begin
    lx = 12'(win_q[0]) + (mode_q ? 12'(win_q[1]) : {3'b0, win_q[1], 1'b0}) + 12'(win_q[2]);
    rx = 12'(top) + (mode_q ? 12'(mid) : {3'b0, mid, 1'b0}) + 12'(px_q);
    ty = 12'(win_q[0]) + (mode_q ? 12'(win_q[3]) : {3'b0, win_q[3], 1'b0}) + 12'(top);
    by = 12'(win_q[2]) + (mode_q ? 12'(win_q[5]) : {3'b0, win_q[5], 1'b0}) + 12'(px_q);
    gx = lx - rx;
    gy = ty - by;
  end

  // Classify the results this item causes.
  always_comb begin
    job       = '0;
    job.mode  = mode_q;
    job.ax    = gx[11] ? 10'(-gx) : 10'(gx);
    job.ay    = gy[11] ? 10'(-gy) : 10'(gy);
    has       = 1'b1;
    if (r_q == '0) begin
      job.row0 = '0;
      job.col0 = 10'(c_q);
    end else if (c_q == '0) begin
      job.row0 = 12'(r_q - RW'(1));
      job.col0 = '0;
      job.two  = (r_q == h_eff - RW'(1));
      job.row1 = 12'(h_eff - RW'(1));
      job.col1 = '0;
    end else if (c_q == CW'(1)) begin
      has      = (r_q == h_eff - RW'(1));
      job.two  = 1'b1;
      job.row0 = 12'(h_eff - RW'(1));
      job.col0 = 10'd1;
      job.row1 = 12'(h_eff - RW'(1));
      job.col1 = 10'd2;
    end else begin
      job.mag  = (r_q >= RW'(2));
      job.row0 = 12'(r_q - RW'(1));
      job.col0 = 10'(c_q - CW'(1));
      if (c_q == w_eff - CW'(1)) begin
        job.two  = 1'b1;
        job.row1 = 12'(r_q - RW'(1));
        job.col1 = 10'(w_eff - CW'(1));
      end else if (r_q == h_eff - RW'(1)) begin
        job.two  = 1'b1;
        job.row1 = 12'(h_eff - RW'(1));
        job.col1 = 10'(c_q + CW'(1));
      end
    end
  end

  assign fire   = (state_q == F_CALC) && (!has || !full_i);
  assign push_o = (state_q == F_CALC) && has && !full_i;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      mode_q  <= spem_pkg::ModeSobel;
      fw_q    <= spem_pkg::FrameWidthRst;
      fh_q    <= spem_pkg::FrameHeightRst;
      col_q   <= '0;
      row_q   <= '0;
      c_q     <= '0;
      r_q     <= '0;
      px_q    <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spem_pkg::RegEdgeMode:    mode_q <= cfg_data_i[0];
          spem_pkg::RegFrameWidth:  fw_q   <= cfg_data_i[10:0];
          spem_pkg::RegFrameHeight: fh_q   <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        F_IDLE: begin
          if (acc) begin
            c_q     <= c1;
            r_q     <= r2;
            px_q    <= pix_i.data.pixel_value;
            state_q <= F_CALC;
            if (nc >= w_eff) begin
              col_q <= '0;
              row_q <= (nr >= h_eff) ? '0 : nr;
            end else begin
              col_q <= nc;
              row_q <= r2;
            end
          end
        end
        F_CALC: begin
          if (fire) begin
            win_q[0] <= win_q[3];
            win_q[1] <= win_q[4];
            win_q[2] <= win_q[5];
            win_q[3] <= top;
            win_q[4] <= mid;
            win_q[5] <= px_q;
            state_q  <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // Line store: upper byte holds the previous row, lower byte the one before.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q <= mem_q[c1[AW-1:0]];
    end
    if (fire) begin
      mem_q[c_q[AW-1:0]] <= {px_q, mid};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spem_queue.sv
// Two-entry job queue between front and back.
`default_nettype none
module spem_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire spem_pkg::job_t job_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      spem_pkg::job_t job_o,
  output      logic           valid_o
);

  spem_pkg::job_t ent_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = ent_q[rp_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (do_pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spem_back.sv
// Back end: bit-serial rounded root of the gradient energy and result emission.
`default_nettype none
module spem_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire spem_pkg::job_t job_i,
  output      logic           pop_o,
  spem_stream_if.source       res_o
);

  typedef enum logic [2:0] {B_IDLE, B_SQ, B_ITER, B_OUT0, B_OUT1} bstate_e;

  bstate_e        state_q;
  spem_pkg::job_t job_q;
  logic [22:0]    s4_q;
  logic [7:0]     root_q;
  logic [2:0]     idx_q;

  logic [7:0]     tr;
  logic [8:0]     q;
  logic [17:0]    qq;
  logic [22:0]    qd;

  assign pop_o = (state_q == B_IDLE);

  always_comb begin
    tr = root_q | (8'd1 << idx_q);
    q  = {tr, 1'b0} - 9'd1;
    qq = 18'(q) * 18'(q);
    qd = (job_q.mode == spem_pkg::ModePrewitt) ? ({1'b0, qq, 4'b0} + {4'b0, qq, 1'b0})
                                               : {qq, 5'b0};
  end

  always_comb begin
    res_o.valid = (state_q == B_OUT0) || (state_q == B_OUT1);
    if (state_q == B_OUT1) begin
      res_o.data.out_row     = job_q.row1;
      res_o.data.out_col     = job_q.col1;
      res_o.data.edge_value  = '0;
      res_o.data.last_of_run = 1'b1;
    end else begin
      res_o.data.out_row     = job_q.row0;
      res_o.data.out_col     = job_q.col0;
      res_o.data.edge_value  = root_q;
      res_o.data.last_of_run = !job_q.two;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      job_q   <= '0;
      s4_q    <= '0;
      root_q  <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          root_q <= '0;
          if (valid_i) begin
            job_q   <= job_i;
            state_q <= job_i.mag ? B_SQ : B_OUT0;
          end
        end
        B_SQ: begin
          s4_q    <= {21'(20'(job_q.ax) * 20'(job_q.ax)) + 21'(20'(job_q.ay) * 20'(job_q.ay)),
                      2'b0};
          idx_q   <= 3'd7;
          state_q <= B_ITER;
        end
        B_ITER: begin
          // keep this bit when its rounding threshold is still reached
          if (qd <= s4_q) begin
            root_q <= tr;
          end
          idx_q <= idx_q - 3'd1;
          if (idx_q == 3'd0) begin
            state_q <= B_OUT0;
          end
        end
        B_OUT0: begin
          if (res_o.ready) begin
            state_q <= job_q.two ? B_OUT1 : B_IDLE;
          end
        end
        B_OUT1: begin
          if (res_o.ready) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sobel_prewitt_edge_magnitude.sv
// Top level of the streaming 3x3 Sobel/Prewitt edge magnitude filter.
//
//  channel  | dir | payload                                       | handshake
//  pix_i    | in  | pixel_value, frame_start                      | valid/ready
//  res_o    | out | out_row, out_col, edge_value, last_of_run     | valid/ready
//  cfg      | in  | cfg_idx_i, cfg_data_i                          | cfg_we_i
//
// The front takes no new pixel until the last is through (line store read, then
// gradients) and waits while the job queue is full. A result without magnitude goes
// straight out; an interior pixel first passes the one-bit-per-cycle root search.
// A two-entry job queue lets the front keep taking pixels while results stall.
// Reset clears counters, window and configuration; the line store is not cleared.
`default_nettype none
module sobel_prewitt_edge_magnitude #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [spem_pkg::IdxW-1:0] cfg_idx_i,
  input  wire logic [spem_pkg::CfgW-1:0] cfg_data_i,
  spem_stream_if.sink                    pix_i,
  spem_stream_if.source                  res_o
);

  logic           push, full, pop, qvalid;
  spem_pkg::job_t job_in, job_out;

  spem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  spem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_out),
    .valid_o (qvalid)
  );

  spem_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (qvalid),
    .job_i   (job_out),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
`default_nettype wire

FILE: rtl/spem_checker.sv
// Port-level checks for the edge magnitude top level, bound to it.
`default_nettype none
module spem_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire spem_pkg::res_t    out_data
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_data.edge_value != 8'd0) |->
      (out_data.out_row != 12'd0) && (out_data.out_col != 10'd0))
    else $error("nonzero magnitude on frame border");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_data.last_of_run |=> out_valid)
    else $error("run ended without its last result");

  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel taken while previous one still in work");

endmodule

bind sobel_prewitt_edge_magnitude spem_checker u_spem_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (pix_i.valid),
  .in_ready  (pix_i.ready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_data  (res_o.data)
);
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the streaming Sobel/Prewitt edge magnitude filter.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [spem_pkg::IdxW-1:0] RegUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [spem_pkg::IdxW-1:0] cfg_idx_i = '0;
  logic [spem_pkg::CfgW-1:0] cfg_data_i = '0;

  spem_stream_if #(.T(spem_pkg::pix_t)) pix_if ();
  spem_stream_if #(.T(spem_pkg::res_t)) res_if ();

  sobel_prewitt_edge_magnitude dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic              mode_q;
  int                width_q, height_q;
  int                line_prev[1024];
  int                line_prev2[1024];
  int                win[6];
  int                cur_row, cur_col;
  spem_pkg::res_t    edge_q[$];

  int         src_idle = 0, snk_idle = 0;
  int         hold_left = 0;
  int         n_err = 0;
  int         n_sent = 0;

  typedef struct {
    logic [7:0] px;
    logic       fs;
    logic       chk;
    int         row, col, val;
  } dir_row_t;

  dir_row_t dir_tab[9] = '{
    '{8'd255, 1'b1, 1'b1, 0, 0, 0},
    '{8'd128, 1'b0, 1'b1, 0, 1, 0},
    '{8'd0,   1'b0, 1'b1, 0, 2, 0},
    '{8'd255, 1'b0, 1'b1, 0, 0, 0},
    '{8'd128, 1'b0, 1'b0, 0, 0, 0},
    '{8'd0,   1'b0, 1'b1, 0, 1, 0},
    '{8'd255, 1'b0, 1'b1, 1, 0, 0},
    '{8'd128, 1'b0, 1'b1, 2, 1, 0},
    '{8'd0,   1'b0, 1'b1, 1, 1, 180}
  };

  function automatic logic [7:0] grad_mag(int t, int m, int b);
    int k, gx, gy;
    longint unsigned ax, ay, s4, d, tr, q;
    logic [7:0] r;
    k = mode_q ? 1 : 2;
    d = mode_q ? 18 : 32;
    gx = (win[0] + k * win[1] + win[2]) - (t + k * m + b);
    gy = (win[0] + k * win[3] + t) - (win[2] + k * win[5] + b);
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    s4 = 4 * (ax * ax + ay * ay);
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      tr = r | (8'd1 << i);
      q = 2 * tr - 1;
      if (q * q * d <= s4) r = r | (8'd1 << i);
    end
    return r;
  endfunction

  // Advance the predictor by one item; return how many results it causes.
  function automatic int predict_edges(input logic [7:0] px, input logic fs,
                                       output spem_pkg::res_t buf0,
                                       output spem_pkg::res_t buf1);
    int w, h, r, c, top, mid, n;
    spem_pkg::res_t bufs[2];
    w = (width_q < 3) ? 3 : (width_q > 1024 ? 1024 : width_q);
    h = (height_q < 3) ? 3 : (height_q > 4096 ? 4096 : height_q);
    n = 0;
    if (fs) begin
      cur_row = 0;
      cur_col = 0;
    end
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    r = cur_row;
    c = cur_col;
    top = line_prev2[c];
    mid = line_prev[c];
    if (r == 0) begin
      bufs[n++] = '{12'(0), 10'(c), 8'd0, 1'b0};
    end else if (c == 0) begin
      bufs[n++] = '{12'(r - 1), 10'd0, 8'd0, 1'b0};
      if (r == h - 1) bufs[n++] = '{12'(h - 1), 10'd0, 8'd0, 1'b0};
    end else if (c == 1) begin
      if (r == h - 1) begin
        bufs[n++] = '{12'(h - 1), 10'd1, 8'd0, 1'b0};
        bufs[n++] = '{12'(h - 1), 10'd2, 8'd0, 1'b0};
      end
    end else begin
      bufs[n++] = '{12'(r - 1), 10'(c - 1),
                    (r >= 2) ? grad_mag(top, mid, px) : 8'd0, 1'b0};
      if (c == w - 1) bufs[n++] = '{12'(r - 1), 10'(w - 1), 8'd0, 1'b0};
      else if (r == h - 1) bufs[n++] = '{12'(h - 1), 10'(c + 1), 8'd0, 1'b0};
    end
    if (n > 0) bufs[n-1].last_of_run = 1'b1;
    line_prev2[c] = mid;
    line_prev[c] = px;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = px;
    cur_col = c + 1;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= h) cur_row = 0;
    end
    buf0 = bufs[0];
    buf1 = bufs[1];
    return n;
  endfunction

  task automatic report_bad(input spem_pkg::res_t exp_r, input spem_pkg::res_t got);
    n_err++;
    if (n_err <= 10)
      $display({"mismatch: expected row %0d col %0d val %0d last %0d,",
                " got row %0d col %0d val %0d last %0d"},
               exp_r.out_row, exp_r.out_col, exp_r.edge_value, exp_r.last_of_run,
               got.out_row, got.out_col, got.edge_value, got.last_of_run);
  endtask

  // Offer one item, hold it until accepted, then record its results.
  task automatic send_pixel(input logic [7:0] px, input logic fs,
                            output spem_pkg::res_t first);
    spem_pkg::res_t b0, b1;
    int n;
    while ($urandom_range(99) < src_idle) begin
      pix_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid = 1'b1;
    pix_if.data = '{px, fs};
    do @(posedge clk_i); while (!pix_if.ready);
    n = predict_edges(px, fs, b0, b1);
    if (n > 0) edge_q.push_back(b0);
    if (n > 1) edge_q.push_back(b1);
    first = b0;
    n_sent++;
    @(negedge clk_i);
    pix_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (edge_q.size() != 0) @(posedge clk_i);
    // Items that cause no result may still be in flight
    repeat (30) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [spem_pkg::IdxW-1:0] idx, input int val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = spem_pkg::CfgW'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      spem_pkg::RegEdgeMode:    mode_q = val[0];
      spem_pkg::RegFrameWidth:  width_q = val & 32'h7FF;
      spem_pkg::RegFrameHeight: height_q = val & 32'h1FFF;
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic mode, input int w, input int h);
    wait_drained();
    write_reg(spem_pkg::RegEdgeMode, int'(mode));
    write_reg(spem_pkg::RegFrameWidth, w);
    write_reg(spem_pkg::RegFrameHeight, h);
  endtask

  function automatic logic [7:0] rand_pix();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Stream count pixels, frame start on the first one when asked and at random (noise percent) on any.
  task automatic send_run(input int count, input logic start, input int noise);
    spem_pkg::res_t f;
    for (int i = 0; i < count; i++)
      send_pixel(rand_pix(), (i == 0 && start) || ($urandom_range(99) < noise), f);
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_if.ready = 1'b0;
    end else begin
      res_if.ready = ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      if (edge_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("unexpected result row %0d col %0d val %0d", res_if.data.out_row,
                   res_if.data.out_col, res_if.data.edge_value);
      end else if (res_if.data !== edge_q[0]) begin
        report_bad(edge_q.pop_front(), res_if.data);
      end else begin
        void'(edge_q.pop_front());
      end
    end
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    spem_pkg::res_t first;
    int w, h;
    pix_if.valid = 1'b0;
    pix_if.data = '0;
    res_if.ready = 1'b0;
    mode_q = spem_pkg::ModeSobel;
    width_q = int'(spem_pkg::FrameWidthRst);
    height_q = int'(spem_pkg::FrameHeightRst);
    for (int i = 0; i < 1024; i++) begin
      line_prev[i] = 0;
      line_prev2[i] = 0;
    end
    for (int i = 0; i < 6; i++) win[i] = 0;
    cur_row = 0;
    cur_col = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: one small frame with a strong vertical edge, in both modes
    src_idle = 17;
    snk_idle = 52;
    for (int m = 0; m < 2; m++) begin
      set_frame(m[0], 3, 3);
      foreach (dir_tab[i]) begin
        send_pixel(dir_tab[i].px, dir_tab[i].fs, first);
        if (dir_tab[i].chk && (first.out_row != 12'(dir_tab[i].row) ||
            first.out_col != 10'(dir_tab[i].col) ||
            first.edge_value != 8'(dir_tab[i].val))) begin
          n_err++;
          if (n_err <= 10)
            $display("directed row %0d: predicted row %0d col %0d val %0d", i,
                     first.out_row, first.out_col, first.edge_value);
        end
      end
    end

    // Sizes out of range clamp to the limits
    set_frame(spem_pkg::ModePrewitt, 0, 0);
    write_reg(RegUnused, 32'h1FFF);
    send_run(14, 1'b1, 0);
    set_frame(spem_pkg::ModeSobel, 2047, 8191);
    send_run(20, 1'b1, 0);

    // Shrink the frame without a frame start so the position lands past it
    set_frame(spem_pkg::ModeSobel, 9, 7);
    send_run(9 * 7 + 9 * 4 + 5, 1'b1, 0);
    set_frame(spem_pkg::ModePrewitt, 4, 3);
    send_run(20, 1'b0, 0);

    // Long receiver hold-off while the sender keeps pushing
    wait_drained();
    hold_left = 400;
    send_run(60, 1'b1, 0);

    n_sent = 0;
    while (n_sent < 460) begin
      if (n_sent < 153) begin
        src_idle = 17;
        snk_idle = 52;
      end else if (n_sent < 306) begin
        src_idle = 52;
        snk_idle = 17;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      set_frame(1'($urandom_range(1)), w, h);
      if ($urandom_range(4) == 0)
        send_run($urandom_range(5, 3 * w * h), 1'b1, 4);
      else
        send_run(w * h * $urandom_range(1, 2) + $urandom_range(w), 1'b1, 0);
    end

    while (edge_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (n_err == 0 && edge_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
